// ----- design/slr_pkg.sv -----
// ----------------------------------------------------------------------------
// slr_pkg - shared types and constants of the slew-limited rate core
// Sequencer states, register indexes, reset values and divider sizing.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int unsigned MsPerSecond = 1000;

  // |dv * 1000| < 2^42, so the quotient magnitude needs 42 bits
  localparam int unsigned DivBits    = 42;
  localparam int unsigned DivCntBits = $clog2(DivBits);

  localparam logic [30:0] StepReset  = 31'd655360;
  localparam logic [15:0] StaleReset = 16'd200;
  localparam logic [15:0] CountMax   = 16'hFFFF;

  typedef enum logic {
    CfgStepLimit  = 1'b0,
    CfgStaleLimit = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StSat,
    StSlew,
    StFin
  } state_e;

endpackage

// ----- design/slew_limited_rate_with_stale_timeout_core.sv -----
// ----------------------------------------------------------------------------
// slew_limited_rate_with_stale_timeout_core - slew-limited rate estimator
// Finite-difference rate with saturation, slew limit and stale timeout.
// ----------------------------------------------------------------------------
// Each transaction carries a millisecond timestamp and a Q16.16 value and
// produces one result: the slew-limited rate per second and a fresh flag.
// A sample with a new timestamp goes from acceptance through a multiply
// by 1000, the restoring divider (one quotient bit per cycle), then the
// saturate, slew and result states before the next acceptance. A sample
// with a repeated timestamp goes straight to the result state. The input
// stalls while a sample is in flight; the result sits in an output
// register, so a new sample may be accepted while it waits.
// Configuration writes are to be issued only while the core is idle.
module slew_limited_rate_with_stale_timeout_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        time_ms_i,
  input  logic signed [31:0] sample_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] limited_rate_o,
  output logic               fresh_o
);

  localparam int unsigned QW = slr_pkg::DivBits;
  localparam int unsigned CW = slr_pkg::DivCntBits;

  slr_pkg::state_e state_q, state_d;

  logic [30:0]        step_limit_q;
  logic [15:0]        stale_limit_q;
  logic [31:0]        prev_time_q;
  logic signed [31:0] prev_value_q;
  logic signed [31:0] rate_q;
  logic [15:0]        stale_count_q;

  logic signed [32:0] dv_q;
  logic [31:0]        dt_q;
  logic               fresh_q;
  logic               neg_q;
  logic [QW-1:0]      quo_q;
  logic [31:0]        rem_q;
  logic [CW-1:0]      div_cnt_q;
  logic signed [31:0] raw_q;

  logic               out_valid_q;
  logic signed [31:0] out_rate_q;
  logic               out_fresh_q;

  logic in_acc, out_free, is_fresh, div_last;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_fresh = (time_ms_i != prev_time_q);
  assign div_last = (div_cnt_q == CW'(QW - 1));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    case (state_q)
      slr_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = is_fresh ? slr_pkg::StMul : slr_pkg::StFin;
        end
      end
      slr_pkg::StMul:  state_d = slr_pkg::StDiv;
      slr_pkg::StDiv:  if (div_last) state_d = slr_pkg::StSat;
      slr_pkg::StSat:  state_d = slr_pkg::StSlew;
      slr_pkg::StSlew: state_d = slr_pkg::StFin;
      slr_pkg::StFin:  if (out_free) state_d = slr_pkg::StIdle;
      default:         state_d = slr_pkg::StIdle;
    endcase
  end

  // datapath
  logic signed [42:0] prod_w;
  logic [42:0]        mag_w;
  logic [32:0]        trial_w;
  logic               ge_w;
  logic signed [33:0] diff_w;
  logic signed [33:0] step_w;
  logic signed [31:0] sat_w;

  assign prod_w  = 43'(dv_q) * $signed(43'(slr_pkg::MsPerSecond));
  assign mag_w   = prod_w[42] ? 43'(-prod_w) : 43'(prod_w);
  assign trial_w = {rem_q, quo_q[QW-1]};
  assign ge_w    = (trial_w >= {1'b0, dt_q});
  assign diff_w  = 34'(raw_q) - 34'(rate_q);
  assign step_w  = $signed({3'b000, step_limit_q});

  always_comb begin
    if (neg_q) begin
      sat_w = (quo_q > QW'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(-quo_q);
    end else begin
      sat_w = (quo_q > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q  <= slr_pkg::StepReset;
      stale_limit_q <= slr_pkg::StaleReset;
      prev_time_q   <= '0;
      prev_value_q  <= '0;
      rate_q        <= '0;
      stale_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (slr_pkg::cfg_idx_e'(cfg_idx_i))
          slr_pkg::CfgStepLimit:  step_limit_q  <= cfg_data_i;
          slr_pkg::CfgStaleLimit: stale_limit_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (is_fresh) begin
          prev_time_q   <= time_ms_i;
          prev_value_q  <= sample_value_i;
          stale_count_q <= '0;
        end else if (stale_count_q != slr_pkg::CountMax) begin
          stale_count_q <= stale_count_q + 16'd1;
        end
      end
      if (state_q == slr_pkg::StSlew) begin
        if (diff_w < -step_w) begin
          rate_q <= 32'(34'(rate_q) - step_w);
        end else if (diff_w > step_w) begin
          rate_q <= 32'(34'(rate_q) + step_w);
        end else begin
          rate_q <= raw_q;
        end
      end
      if (state_q == slr_pkg::StFin && out_free) begin
        // stale timeout zeroes the held rate
        if (stale_count_q > stale_limit_q) begin
          rate_q <= '0;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      slr_pkg::StIdle: begin
        if (in_acc) begin
          dv_q    <= 33'(sample_value_i) - 33'(prev_value_q);
          dt_q    <= time_ms_i - prev_time_q;
          fresh_q <= is_fresh;
        end
      end
      slr_pkg::StMul: begin
        neg_q     <= prod_w[42];
        quo_q     <= mag_w[QW-1:0];
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      slr_pkg::StDiv: begin
        // one restoring step: quotient bit in from the right
        rem_q     <= ge_w ? 32'(trial_w - {1'b0, dt_q}) : trial_w[31:0];
        quo_q     <= {quo_q[QW-2:0], ge_w};
        div_cnt_q <= div_cnt_q + CW'(1);
      end
      slr_pkg::StSat: raw_q <= sat_w;
      slr_pkg::StFin: begin
        if (out_free) begin
          out_rate_q  <= (stale_count_q > stale_limit_q) ? 32'sd0 : rate_q;
          out_fresh_q <= fresh_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign limited_rate_o = out_rate_q;
  assign fresh_o        = out_fresh_q;

`ifndef ASSERT_OFF
  a_rem_below_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slr_pkg::StDiv |-> rem_q < dt_q)
    else $error("divider remainder not below divisor");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slr_pkg::StDiv && div_last |=> state_q == slr_pkg::StSat)
    else $error("divider did not finish after last step");

  a_repeat_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_fresh |=> state_q == slr_pkg::StFin && !fresh_q)
    else $error("repeated timestamp entered the divider");

  a_fresh_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == slr_pkg::StFin && fresh_q |-> stale_count_q == '0)
    else $error("stale counter not cleared on fresh sample");
`endif

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - self-checking bench for slew_limited_rate_with_stale_timeout_core
// Drives timestamped Q16.16 samples and predicts every result in SV: the
// finite-difference rate with saturation, the slew limit and the stale
// timeout. Each result is compared in order. Sender and receiver idle at
// random, and the bench runs through several register settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DrainPause = 50;  // longer than the fresh-sample path through the core

  typedef struct packed {
    logic signed [31:0] rate;
    logic               fresh;
  } rate_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic               cfg_idx_i      = 1'b0;
  logic [30:0]        cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [31:0]        time_ms_i      = '0;
  logic signed [31:0] sample_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic signed [31:0] limited_rate_o;
  logic               fresh_o;

  slew_limited_rate_with_stale_timeout_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .time_ms_i      (time_ms_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .limited_rate_o (limited_rate_o),
    .fresh_o        (fresh_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state and registers
  logic [30:0]        step_lim;
  logic [15:0]        stale_lim;
  logic [31:0]        pred_time;
  logic signed [31:0] last_value;
  logic signed [31:0] rate_q;
  logic [15:0]        idle_calls;

  rate_result_t expected_rates[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_errors       = 0;
  int n_sent         = 0;
  int n_fresh        = 0;
  int n_zeroed       = 0;
  int n_writes       = 0;

  function automatic void predict_rate(input logic [31:0] t, input logic signed [31:0] v);
    longint       dv, dt, raw, cur, stp, diff;
    logic         is_fresh;
    rate_result_t res;
    is_fresh = (t != pred_time);
    if (idle_calls != slr_pkg::CountMax) idle_calls = idle_calls + 16'd1;
    if (is_fresh) begin
      dt   = longint'({32'b0, t - pred_time});
      dv   = longint'(v) - longint'(last_value);
      raw  = (dv * longint'(slr_pkg::MsPerSecond)) / dt;
      if (raw > 64'sd2147483647) raw = 64'sd2147483647;
      if (raw < -64'sd2147483648) raw = -64'sd2147483648;
      cur  = longint'(rate_q);
      stp  = longint'({33'b0, step_lim});
      diff = raw - cur;
      if (diff < -stp) cur = cur - stp;
      else if (diff > stp) cur = cur + stp;
      else cur = raw;
      rate_q     = cur[31:0];
      pred_time  = t;
      last_value = v;
      idle_calls = '0;
    end
    if (idle_calls > stale_lim) begin
      rate_q   = '0;
      n_zeroed++;
    end
    res.rate  = rate_q;
    res.fresh = is_fresh;
    expected_rates.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    n_errors++;
  endtask

  // one transaction in; called at a rising edge, returns at the accepting edge
  task automatic send_sample(input logic [31:0] t, input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    time_ms_i      <= t;
    sample_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_rate(t, v);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rates.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input slr_pkg::cfg_idx_e idx, input logic [30:0] data);
    wait_drained();
    repeat (DrainPause) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == slr_pkg::CfgStepLimit) step_lim = data;
    else stale_lim = data[15:0];
    n_writes++;
  endtask

  // receiver side: random stall, sampled values are pre-edge
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    rate_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rates.size() == 0) begin
        report_mismatch("result with nothing pending, rate", 0, limited_rate_o);
      end else begin
        want = expected_rates.pop_front();
        if (limited_rate_o !== want.rate)
          report_mismatch("limited_rate", want.rate, limited_rate_o);
        if (fresh_o !== want.fresh)
          report_mismatch("fresh", want.fresh, fresh_o);
        if (want.fresh) n_fresh++;
      end
    end
  end

  // time zero after reset is not fresh; then both saturation directions
  task automatic test_first_sample();
    send_sample(32'd0, 32'h0000_0000);
    send_sample(32'd1, 32'h7FFF_FFFF);
    send_sample(32'd2, 32'h8000_0000);
    send_sample(32'd3, 32'h8000_0000);
  endtask

  task automatic test_slew_extremes();
    write_register(slr_pkg::CfgStepLimit, 31'h7FFF_FFFF);
    send_sample(32'd4, 32'h7FFF_FFFF);
    send_sample(32'd5, 32'h8000_0000);
    send_sample(32'd7, 32'h0001_0000);
    write_register(slr_pkg::CfgStepLimit, 31'd0);
    send_sample(32'd9, 32'h7FFF_FFFF);
    send_sample(32'd1000, 32'h0000_1234);
    write_register(slr_pkg::CfgStepLimit, slr_pkg::StepReset);
  endtask

  // modulo-2^32 differences, including the largest possible one
  task automatic test_timestamp_wrap();
    send_sample(32'hFFFF_FFFF, 32'h0001_0000);
    send_sample(32'h0000_0003, 32'h0002_0000);
    send_sample(32'h0000_0002, 32'hFFFF_0000);
    send_sample(32'hAAAA_5555, 32'h5555_AAAA);
    send_sample(32'h5555_AAAA, 32'hAAAA_5555);
  endtask

  task automatic test_stale_timeout();
    write_register(slr_pkg::CfgStaleLimit, 16'd0);
    send_sample(32'd10, 32'h0100_0000);
    send_sample(32'd10, 32'h0100_0000);   // any repeat zeroes the rate
    write_register(slr_pkg::CfgStaleLimit, 16'd3);
    send_sample(32'd11, 32'h0200_0000);
    repeat (5) send_sample(32'd11, 32'h0300_0000);
    write_register(slr_pkg::CfgStaleLimit, 16'hFFFF);
    send_sample(32'd12, 32'h0400_0000);
    repeat (3) send_sample(32'd12, 32'h0000_0000);
    write_register(slr_pkg::CfgStaleLimit, slr_pkg::StaleReset);
  endtask

  // well-formed tracks with random content, repeat bursts and some noise
  task automatic test_random_tracking(input int segments, input int per_segment);
    logic [31:0] cur_t;
    logic [31:0] cur_v;
    logic [31:0] delta;
    int          sel;
    int          reps;
    int          scale;
    cur_t = pred_time;
    cur_v = last_value;
    for (int s = 0; s < segments; s++) begin
      sel = $urandom_range(4);
      case (sel)
        0: write_register(slr_pkg::CfgStepLimit, 31'd0);
        1: write_register(slr_pkg::CfgStepLimit, 31'h7FFF_FFFF);
        2: write_register(slr_pkg::CfgStepLimit, slr_pkg::StepReset);
        3: write_register(slr_pkg::CfgStepLimit, 31'($urandom_range(1, 1 << 22)));
        default: write_register(slr_pkg::CfgStepLimit, 31'($urandom()));
      endcase
      sel = $urandom_range(4);
      case (sel)
        0: write_register(slr_pkg::CfgStaleLimit, 16'd0);
        1: write_register(slr_pkg::CfgStaleLimit, 16'hFFFF);
        2: write_register(slr_pkg::CfgStaleLimit, 16'($urandom_range(1, 10)));
        3: write_register(slr_pkg::CfgStaleLimit, slr_pkg::StaleReset);
        default: write_register(slr_pkg::CfgStaleLimit, 16'($urandom()));
      endcase
      scale = 4 << (4 * $urandom_range(0, 5));
      for (int i = 0; i < per_segment; i++) begin
        sel   = $urandom_range(99);
        delta = 32'($urandom_range(0, 2 * scale)) - 32'(scale);
        if (sel < 70) begin
          cur_t = cur_t + 32'($urandom_range(1, 30));
          cur_v = cur_v + delta;
          send_sample(cur_t, cur_v);
        end else if (sel < 82) begin
          reps = $urandom_range(1, 12);
          for (int r = 0; r < reps && i < per_segment; r++, i++)
            send_sample(cur_t, $urandom());
        end else if (sel < 92) begin
          cur_t = cur_t + 32'($urandom_range(1, 65535));
          cur_v = $urandom();
          send_sample(cur_t, cur_v);
        end else begin
          cur_t = $urandom();
          cur_v = $urandom();
          send_sample(cur_t, cur_v);
        end
        if ($urandom_range(49) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    step_lim   = slr_pkg::StepReset;
    stale_lim  = slr_pkg::StaleReset;
    pred_time  = '0;
    last_value = '0;
    rate_q     = '0;
    idle_calls = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 38;
    recv_stall_pct = 62;
    test_first_sample();
    test_slew_extremes();
    test_timestamp_wrap();
    test_stale_timeout();
    test_random_tracking(10, 62);

    send_idle_pct  = 62;
    recv_stall_pct = 38;
    test_random_tracking(10, 62);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_tracking(10, 62);

    wait_drained();
    repeat (DrainPause) @(posedge clk_i);
    if (expected_rates.size() != 0)
      report_mismatch("results still pending at end", 0, expected_rates.size());

    $display("covered %0d transactions: %0d fresh estimates, %0d stale zeroings",
             n_sent, n_fresh, n_zeroed);
    $display("across %0d register writes and three idle/stall mixes", n_writes);
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout waiting for the core");
    $display("testbench NOT OK");
    $finish;
  end

endmodule
